// ----- hw/rtl/frmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frmp_pkg;

   localparam int SAMPLES      = 10;
   localparam int TICK_W       = 32;
   localparam int INTERVAL_W   = 16;
   localparam int TARGET_W     = 10;
   localparam int DELAY_W      = 10;
   localparam int FPS_W        = 22;

   localparam int SLOT_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int FILL_W       = $clog2(SAMPLES + 1);
   localparam int SUM_W        = INTERVAL_W + FILL_W;

   localparam int FPS_SCALE    = 256000;
   localparam int NUM_W        = $clog2(FPS_SCALE * SAMPLES + 1);
   localparam int DIV_W        = (NUM_W > FPS_W) ? NUM_W : FPS_W;
   localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

   localparam int FPS_MAX      = 4194303;
   localparam int FPS_DEFAULT  = 15360;
   localparam int PERIOD_NUM   = 1000;
   localparam int TARGET_RESET = 60;
   localparam int INTERVAL_MAX = 65535;

   typedef enum logic {
      OP_BEGIN = 1'b0,
      OP_END   = 1'b1
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SUM      = 7'b0000010,
      ST_FPS_GO   = 7'b0000100,
      ST_FPS_WAIT = 7'b0001000,
      ST_PER_GO   = 7'b0010000,
      ST_PER_WAIT = 7'b0100000,
      ST_OUT      = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/frmp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface frmp_req_if import frmp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [TICK_W-1:0] tick_ms;

   modport source (output valid, output operation, output tick_ms, input ready);
   modport sink   (input valid, input operation, input tick_ms, output ready);
endinterface

interface frmp_rsp_if import frmp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FPS_W-1:0]      fps_q8;
   logic [INTERVAL_W-1:0] frame_time_ms;
   logic [DELAY_W-1:0]    delay_ms;

   modport source (output valid, output fps_q8, output frame_time_ms, output delay_ms,
                   input ready);
   modport sink   (input valid, input fps_q8, input frame_time_ms, input delay_ms,
                   output ready);
endinterface

interface frmp_csr_if import frmp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target_fps;

   modport source (output valid, output target_fps, input ready);
   modport sink   (input valid, input target_fps, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frmp_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frmp_divider import frmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       rem_sh;
   logic [DIV_W+1:0]     diff;

   assign rem_sh = {rem_ff, quot_ff[DIV_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W+1]) begin
            rem_in  = diff[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/frame_rate_meter_and_pacer_top.sv -----
// Frame rate meter and pacer.
// The req_ch channel takes frame events: operation 0 marks a frame begin and
// records tick_ms as the frame start, operation 1 marks a frame end. A begin item
// is taken and gives no result. An end item gives one item on rsp_ch
// with the averaged rate as unsigned fixed point with 8 fraction bits, the saturated
// interval since the previous end, and the milliseconds still to wait to hold the
// target rate.
// The csr_ch channel writes target_fps and is always ready; write it while idle.
// An end item sums the stored intervals of the ring one by one, then makes two passes
// of one shared restoring divider, first for the rate and then for the frame period;
// each pass retires the 22 quotient bits. req_ch is not ready until an end item's
// result is in the output register, so the block takes no new item meanwhile.
// The result sits in an output register, so a stalled receiver holds the result
// and the block goes back to accept new items; only the next result then waits.
// Reset empties the interval ring, clears the previous-end and frame-start ticks
// and sets target_fps to 60.
`timescale 1ns / 1ps
`default_nettype none

module frame_rate_meter_and_pacer_top import frmp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   frmp_req_if.sink   req_ch,
   frmp_rsp_if.source rsp_ch,
   frmp_csr_if.sink   csr_ch
);

   state_type              state_ff, state_in;
   logic [INTERVAL_W-1:0]  ring_ff [SAMPLES];
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [TICK_W-1:0]      prev_end_ff, prev_end_in;
   logic [TICK_W-1:0]      start_tick_ff, start_tick_in;
   logic                   seen_ff, seen_in;
   logic [TARGET_W-1:0]    target_ff;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [TICK_W-1:0]      elapsed_ff, elapsed_in;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in;
   logic [FPS_W-1:0]       fps_ff, fps_in;
   logic [DELAY_W-1:0]     period_ff, period_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FPS_W-1:0]       rsp_fps_ff, rsp_fps_in;
   logic [INTERVAL_W-1:0]  rsp_time_ff, rsp_time_in;
   logic [DELAY_W-1:0]     rsp_delay_ff, rsp_delay_in;

   logic                   req_fire;
   logic                   ring_we;
   logic [TICK_W-1:0]      end_diff;
   logic [INTERVAL_W-1:0]  new_interval;
   logic [TARGET_W-1:0]    target_div;
   logic                   div_start;
   logic                   div_done;
   logic [DIV_W-1:0]       div_dividend;
   logic [DIV_W-1:0]       div_divisor;
   logic [DIV_W-1:0]       div_quot;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign ring_we      = req_fire && (req_ch.operation == OP_END);
   assign csr_ch.ready = 1'b1;

   assign end_diff     = req_ch.tick_ms - prev_end_ff;
   assign new_interval = !seen_ff ? '0 :
                         (end_diff > TICK_W'(INTERVAL_MAX)) ? INTERVAL_W'(INTERVAL_MAX) :
                         end_diff[INTERVAL_W-1:0];
   assign target_div   = (target_ff == '0) ? TARGET_W'(1) : target_ff;

   always_comb begin
      div_start = (state_ff == ST_FPS_GO) || (state_ff == ST_PER_GO);
      if (state_ff == ST_PER_GO) begin
         div_dividend = DIV_W'(PERIOD_NUM);
         div_divisor  = DIV_W'(target_div);
      end else begin
         div_dividend = DIV_W'(FPS_SCALE) * DIV_W'(fill_ff);
         div_divisor  = DIV_W'(sum_ff);
      end
   end

   frmp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      prev_end_in   = prev_end_ff;
      start_tick_in = start_tick_ff;
      seen_in       = seen_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      elapsed_in    = elapsed_ff;
      interval_in   = interval_ff;
      fps_in        = fps_ff;
      period_in     = period_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_fps_in    = rsp_fps_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_delay_in  = rsp_delay_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.operation == OP_END) begin
                  interval_in = new_interval;
                  elapsed_in  = req_ch.tick_ms - start_tick_ff;
                  prev_end_in = req_ch.tick_ms;
                  seen_in     = 1'b1;
                  slot_in     = (slot_ff == SLOT_W'(SAMPLES - 1)) ? '0 : slot_ff + 1'b1;
                  if (fill_ff != FILL_W'(SAMPLES)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  start_tick_in = req_ch.tick_ms;
               end
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + SUM_W'(ring_ff[idx_ff]);
            idx_in = idx_ff + 1'b1;
            if (FILL_W'(idx_ff) + FILL_W'(1) == fill_ff) begin
               state_in = ST_FPS_GO;
            end
         end
         ST_FPS_GO: begin
            state_in = ST_FPS_WAIT;
         end
         ST_FPS_WAIT: begin
            if (div_done) begin
               if (sum_ff == '0) begin
                  fps_in = FPS_W'(FPS_DEFAULT);
               end else if (div_quot > DIV_W'(FPS_MAX)) begin
                  fps_in = FPS_W'(FPS_MAX);
               end else begin
                  fps_in = div_quot[FPS_W-1:0];
               end
               state_in = ST_PER_GO;
            end
         end
         ST_PER_GO: begin
            state_in = ST_PER_WAIT;
         end
         ST_PER_WAIT: begin
            if (div_done) begin
               period_in = div_quot[DELAY_W-1:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fps_in   = fps_ff;
               rsp_time_in  = interval_ff;
               if (TICK_W'(period_ff) > elapsed_ff) begin
                  rsp_delay_in = DELAY_W'(TICK_W'(period_ff) - elapsed_ff);
               end else begin
                  rsp_delay_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_ff[slot_ff] <= new_interval;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      elapsed_ff   <= elapsed_in;
      interval_ff  <= interval_in;
      fps_ff       <= fps_in;
      period_ff    <= period_in;
      rsp_fps_ff   <= rsp_fps_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_delay_ff <= rsp_delay_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         fill_ff       <= '0;
         prev_end_ff   <= '0;
         start_tick_ff <= '0;
         seen_ff       <= 1'b0;
         target_ff     <= TARGET_W'(TARGET_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         prev_end_ff   <= prev_end_in;
         start_tick_ff <= start_tick_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            target_ff <= csr_ch.target_fps;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.fps_q8        = rsp_fps_ff;
   assign rsp_ch.frame_time_ms = rsp_time_ff;
   assign rsp_ch.delay_ms      = rsp_delay_ff;

endmodule

`default_nettype wire

// ----- sim/tb_frame_rate_meter_and_pacer_top.sv -----
`timescale 1ns / 1ps

module tb_frame_rate_meter_and_pacer_top;
   import frmp_pkg::*;

   localparam int SEGMENTS        = 12;
   localparam int SEGMENT_ITEMS   = 128;
   localparam int SETTLE_CYCLES   = 80;
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int MAX_REPORTS     = 10;
   localparam int TIMEOUT_NS      = 2_000_000;

   typedef struct packed {
      logic [FPS_W-1:0]      fps_q8;
      logic [INTERVAL_W-1:0] frame_time_ms;
      logic [DELAY_W-1:0]    delay_ms;
   } frame_report_type;

   typedef struct {
      op_type           op;
      logic [31:0]      tick;
      bit               typed;
      frame_report_type report;
   } event_row_type;

   logic clock;
   logic reset;

   frmp_req_if req_ch ();
   frmp_rsp_if rsp_ch ();
   frmp_csr_if csr_ch ();

   frame_rate_meter_and_pacer_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow state of the meter.
   logic [INTERVAL_W-1:0] ring_q [SAMPLES];
   int                    slot_q        = 0;
   int                    fill_q        = 0;
   logic [TICK_W-1:0]     last_end_q    = '0;
   logic [TICK_W-1:0]     frame_start_q = '0;
   bit                    seen_end_q    = 1'b0;
   logic [TARGET_W-1:0]   target_q      = TARGET_W'(TARGET_RESET);

   frame_report_type pending_reports [$];
   int               error_count   = 0;
   int               reports_seen  = 0;
   int               send_idle_pct = 0;
   int               rsp_idle_pct  = 0;
   int               hold_requests = 0;
   logic [31:0]      wall_ms       = '0;

   event_row_type directed_rows [21] = '{
      '{OP_END,   32'h0000_0000, 1'b1, '{22'd15360, 16'd0, 10'd16}},
      '{OP_END,   32'h0000_0000, 1'b1, '{22'd15360, 16'd0, 10'd16}},
      '{OP_BEGIN, 32'd100,       1'b0, '0},
      '{OP_END,   32'd110,       1'b0, '0},
      '{OP_BEGIN, 32'd200,       1'b0, '0},
      '{OP_END,   32'd216,       1'b0, '0},
      '{OP_BEGIN, 32'd300,       1'b0, '0},
      '{OP_END,   32'd315,       1'b0, '0},
      '{OP_BEGIN, 32'hFFFF_FFF8, 1'b0, '0},
      '{OP_END,   32'h0000_0004, 1'b0, '0},
      '{OP_END,   32'h0000_0004, 1'b0, '0},
      '{OP_BEGIN, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_END,   32'hFFFF_FFFF, 1'b0, '0},
      '{OP_BEGIN, 32'h5555_5555, 1'b0, '0},
      '{OP_END,   32'hAAAA_AAAA, 1'b0, '0},
      '{OP_BEGIN, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_END,   32'hAAAB_AAA9, 1'b0, '0},
      '{OP_END,   32'hAAAC_AAA9, 1'b0, '0},
      '{OP_END,   32'hAAAC_AAAA, 1'b0, '0},
      '{OP_END,   32'hAAAC_AAAB, 1'b0, '0},
      '{OP_END,   32'hAAAC_AAAC, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] pace_period(logic [TARGET_W-1:0] target);
      return PERIOD_NUM / ((target == 0) ? 1 : target);
   endfunction

   function automatic bit predict_frame_report(op_type op, logic [TICK_W-1:0] tick,
                                               output frame_report_type report);
      logic [TICK_W-1:0] diff;
      logic [TICK_W-1:0] elapsed;
      logic [31:0]       period;
      logic [31:0]       sum;
      logic [63:0]       rate;
      logic [15:0]       interval;
      report = '0;
      if (op == OP_BEGIN) begin
         frame_start_q = tick;
         return 1'b0;
      end
      diff = tick - last_end_q;
      if (!seen_end_q) begin
         interval = '0;
      end else if (diff > INTERVAL_MAX) begin
         interval = 16'hFFFF;
      end else begin
         interval = diff[15:0];
      end
      last_end_q = tick;
      seen_end_q = 1'b1;
      ring_q[slot_q] = interval;
      slot_q = (slot_q == SAMPLES - 1) ? 0 : slot_q + 1;
      if (fill_q < SAMPLES) begin
         fill_q++;
      end
      sum = 0;
      for (int i = 0; i < fill_q; i++) begin
         sum += ring_q[i];
      end
      if (sum == 0) begin
         rate = FPS_DEFAULT;
      end else begin
         rate = (64'(FPS_SCALE) * 64'(fill_q)) / 64'(sum);
         if (rate > FPS_MAX) begin
            rate = FPS_MAX;
         end
      end
      period  = pace_period(target_q);
      elapsed = tick - frame_start_q;
      report.fps_q8        = rate[FPS_W-1:0];
      report.frame_time_ms = interval;
      report.delay_ms      = (period > elapsed) ? DELAY_W'(period - elapsed) : '0;
      return 1'b1;
   endfunction

   task automatic send_event(op_type op, logic [TICK_W-1:0] tick, bit typed = 1'b0,
                             frame_report_type typed_report = '0);
      frame_report_type report;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.tick_ms   <= tick;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      if (predict_frame_report(op, tick, report)) begin
         pending_reports.push_back(typed ? typed_report : report);
      end
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(logic [TARGET_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.target_fps <= value;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      target_q = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_segment(int budget);
      int          sent;
      int          kind;
      logic [31:0] period;
      logic [31:0] elapsed;
      sent = 0;
      while (sent < budget) begin
         kind   = $urandom_range(99);
         period = pace_period(target_q);
         if (kind < 78) begin
            elapsed = $urandom_range(period + 4);
            if ($urandom_range(9) == 0) begin
               elapsed = $urandom_range(3 * period + 20);
            end
            send_event(OP_BEGIN, wall_ms);
            wall_ms += elapsed;
            send_event(OP_END, wall_ms);
            wall_ms += $urandom_range(8);
            sent += 2;
         end else if (kind < 82) begin
            // Nine zero intervals and one of a single tick give the top rate.
            for (int k = 0; k < 10; k++) begin
               send_event(OP_END, wall_ms);
            end
            wall_ms += 1;
            send_event(OP_END, wall_ms);
            sent += 11;
         end else if (kind < 86) begin
            wall_ms += ($urandom_range(1) == 0) ? 32'(65536 + $urandom_range(65535))
                                                : $urandom;
         end else if (kind < 92) begin
            send_event(OP_END, wall_ms + $urandom_range(40));
            sent += 1;
         end else begin
            send_event(op_type'($urandom_range(1)), $urandom);
            sent += 1;
         end
      end
      stop_sending();
   endtask

   initial begin : rsp_ready_driver
      int hold_left;
      int holds_done;
      hold_left     = 0;
      holds_done    = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            hold_left  = RSP_HOLD_CYCLES;
            holds_done = hold_requests;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : report_checker
      frame_report_type got;
      frame_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.fps_q8        = rsp_ch.fps_q8;
         got.frame_time_ms = rsp_ch.frame_time_ms;
         got.delay_ms      = rsp_ch.delay_ms;
         if (pending_reports.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("unexpected report %0d: fps_q8 %0d frame_time_ms %0d delay_ms %0d",
                        reports_seen, got.fps_q8, got.frame_time_ms, got.delay_ms);
            end
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("frame report %0d: fps_q8 exp %0d got %0d",
                           reports_seen, want.fps_q8, got.fps_q8);
                  $display("   frame_time_ms exp %0d got %0d, delay_ms exp %0d got %0d",
                           want.frame_time_ms, got.frame_time_ms,
                           want.delay_ms, got.delay_ms);
               end
            end
         end
         reports_seen++;
      end
   end

   initial begin : stimulus
      logic [TARGET_W-1:0] target;
      foreach (ring_q[i]) begin
         ring_q[i] = '0;
      end
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_BEGIN;
      req_ch.tick_ms    = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.target_fps = '0;
      reset             = 1'b1;
      send_idle_pct     = 6;
      rsp_idle_pct      = 60;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_event(directed_rows[i].op, directed_rows[i].tick, directed_rows[i].typed,
                    directed_rows[i].report);
      end
      stop_sending();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 4) begin
            send_idle_pct = 60;
            rsp_idle_pct  = 6;
         end else if (seg == 8) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         case (seg)
            0:       target = 10'd60;
            1:       target = 10'd1;
            2:       target = 10'd1000;
            3:       target = 10'd0;
            4:       target = 10'd1023;
            5:       target = 10'd144;
            6:       target = TARGET_W'($urandom_range(1, 1000));
            7:       target = 10'd30;
            8:       target = 10'd500;
            9:       target = TARGET_W'($urandom_range(1023));
            10:      target = 10'd240;
            default: target = 10'd7;
         endcase
         write_target(target);
         wall_ms = (seg % 3 == 0) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom;
         if (seg == 9) begin
            hold_requests++;
         end
         run_segment(SEGMENT_ITEMS);
      end

      wait_drained();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/frmp_pkg.sv
hw/rtl/frmp_if.sv
hw/rtl/frmp_divider.sv
hw/rtl/frame_rate_meter_and_pacer_top.sv
sim/tb_frame_rate_meter_and_pacer_top.sv
